// ----- sv/dvrt_pkg.sv -----
// shared types and constants for the distance vector route table
// no dependencies
`default_nettype none

package dvrt_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_REQUEST = 3'd1;
  localparam logic [2:0] OP_ADVERT  = 3'd2;
  localparam logic [2:0] OP_LOCAL   = 3'd3;
  localparam logic [2:0] OP_LOOKUP  = 3'd4;

  localparam logic [1:0] KIND_CHANGED = 2'd0;
  localparam logic [1:0] KIND_LOOKUP  = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET  = 8'd12;
  localparam logic [4:0] INFINITY_RESET = 5'd16;

  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_INFINITY = 1'b1;

  // classified command from the front part to the scan engine
  typedef enum logic [4:0] {
    CMD_TICK   = 5'b00001,
    CMD_STORE  = 5'b00010,
    CMD_ADVERT = 5'b00100,
    CMD_LOOKUP = 5'b01000,
    CMD_NONE   = 5'b10000
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  cost;
    logic        unreachable;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        found;
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  cost;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/dvrt_front.sv -----
// front part: classifies input items into scan commands and queues them
// depends on dvrt_pkg
`default_nettype none

module dvrt_front
  import dvrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] route_dest,
  input  wire logic [31:0] sender_address,
  input  wire logic [4:0]  advertised_cost,
  input  wire logic [4:0]  infinity_cost,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_take
);

  // two entry command queue
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic [5:0] adv_inc;
  logic       push_ok;
  logic       pop_ok;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_take && cmd_valid;
  assign adv_inc   = {1'b0, advertised_cost} + 6'd1;

  // decode opcode and precompute the new cost
  always_comb begin
    cls.dest        = route_dest;
    cls.hop         = sender_address;
    cls.cost        = 5'd0;
    cls.unreachable = 1'b0;
    cls.kind        = CMD_NONE;
    case (opcode)
      OP_TICK: begin
        cls.kind = CMD_TICK;
      end
      OP_REQUEST: begin
        cls.kind = CMD_STORE;
        cls.dest = sender_address;
        cls.cost = (infinity_cost > 5'd1) ? 5'd1 : infinity_cost;
      end
      OP_ADVERT: begin
        cls.kind        = CMD_ADVERT;
        cls.unreachable = (advertised_cost >= infinity_cost);
        if (cls.unreachable || adv_inc > {1'b0, infinity_cost}) begin
          cls.cost = infinity_cost;
        end else begin
          cls.cost = adv_inc[4:0];
        end
      end
      OP_LOCAL: begin
        cls.kind = CMD_STORE;
        cls.hop  = route_dest;
      end
      OP_LOOKUP: begin
        cls.kind = CMD_LOOKUP;
      end
      default: begin
        cls.kind = CMD_NONE;
      end
    endcase
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (!push_ok && pop_ok) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/dvrt_engine.sv -----
// back part: scans the route table memory once per command other than an unused opcode and emits results
// depends on dvrt_pkg
`default_nettype none

module dvrt_engine
  import dvrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] timeout_seconds,
  input  wire logic [4:0] infinity_cost,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            cmd_take,
  output logic            res_valid,
  output result_t         res,
  input  wire logic       res_take
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  cost;
    logic [7:0]  age;
  } entry_t;

  // table memory with flop valid bits
  entry_t                  mem [TableEntries];
  logic [TableEntries-1:0] valid;

  state_t      state;
  cmd_t        cur;
  logic [CntW-1:0] rd_cnt;
  logic [IdxW-1:0] cmp_idx;
  logic            cmp_live;
  entry_t          rd_data;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  entry_t          hit_entry;
  logic            have_free;
  logic [IdxW-1:0] free_idx;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  entry_t          wr_data;
  logic [7:0]      aged;

  assign cmd_take = (state == ST_IDLE) && cmd_valid;
  assign aged     = (rd_data.age == 8'hFF) ? 8'hFF : rd_data.age + 8'd1;

  // memory read and write
  always_ff @(posedge clk) begin
    if (rd_cnt < CntW'(TableEntries)) begin
      rd_data <= mem[rd_cnt[IdxW-1:0]];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // write port select: tick writes back aged entries, apply writes one slot
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmp_idx;
    wr_data = rd_data;
    if (state == ST_SCAN && cmp_live && cur.kind == CMD_TICK) begin
      wr_en       = valid[cmp_idx];
      wr_data.age = aged;
    end else if (state == ST_APPLY) begin
      wr_data.dest = cur.dest;
      wr_data.hop  = cur.hop;
      wr_data.cost = cur.cost;
      wr_data.age  = 8'd0;
      if (cur.kind == CMD_STORE) begin
        wr_en  = hit || have_free;
        wr_idx = hit ? hit_idx : free_idx;
      end else if (cur.kind == CMD_ADVERT) begin
        wr_idx = hit ? hit_idx : free_idx;
        if (!hit) begin
          wr_en = !cur.unreachable && have_free;
        end else if (cur.cost < hit_entry.cost ||
                     (cur.cost > hit_entry.cost && hit_entry.hop == cur.hop)) begin
          wr_en = 1'b1;
        end else if (hit_entry.hop == cur.hop && !cur.unreachable) begin
          wr_en        = 1'b1;
          wr_data.dest = hit_entry.dest;
          wr_data.cost = hit_entry.cost;
        end
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
      rd_cnt    <= '0;
      cmp_live  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur       <= cmd;
            hit       <= 1'b0;
            have_free <= 1'b0;
            rd_cnt    <= '0;
            cmp_live  <= 1'b0;
            if (cmd.kind == CMD_NONE) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // address stage, one entry per cycle
          if (rd_cnt < CntW'(TableEntries)) begin
            rd_cnt <= rd_cnt + CntW'(1);
          end
          cmp_live <= (rd_cnt < CntW'(TableEntries));
          cmp_idx  <= rd_cnt[IdxW-1:0];
          // compare stage on registered read data
          if (cmp_live) begin
            if (cur.kind == CMD_TICK) begin
              if (valid[cmp_idx] && aged >= timeout_seconds) begin
                valid[cmp_idx] <= 1'b0;
              end
            end else begin
              if (valid[cmp_idx] && rd_data.dest == cur.dest && !hit) begin
                hit       <= 1'b1;
                hit_idx   <= cmp_idx;
                hit_entry <= rd_data;
              end
              if (!valid[cmp_idx] && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= cmp_idx;
              end
            end
            if (cmp_idx == IdxW'(TableEntries - 1)) begin
              state <= (cur.kind == CMD_TICK) ? ST_IDLE : ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (wr_en) begin
            valid[wr_idx] <= 1'b1;
          end
          res.dest <= cur.dest;
          if (cur.kind == CMD_LOOKUP) begin
            res.kind  <= KIND_LOOKUP;
            res.found <= hit;
            res.hop   <= hit ? hit_entry.hop : 32'd0;
            res.cost  <= hit ? hit_entry.cost : 5'd0;
            res_valid <= 1'b1;
            state     <= ST_OUT;
          end else begin
            res.found <= 1'b0;
            res.hop   <= cur.hop;
            res.cost  <= cur.cost;
            if (!wr_en && (cur.kind == CMD_STORE ||
                (!hit && !cur.unreachable))) begin
              res.kind  <= KIND_FULL;
              res_valid <= 1'b1;
              state     <= ST_OUT;
            end else if (cur.kind == CMD_ADVERT && hit && wr_data.dest == cur.dest &&
                         wr_en && (cur.cost < hit_entry.cost ||
                         (cur.cost > hit_entry.cost && hit_entry.hop == cur.hop))) begin
              res.kind  <= KIND_CHANGED;
              res_valid <= 1'b1;
              state     <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (res_take) begin
            res_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/distance_vector_route_table.sv -----
// top level of the distance vector route table
// depends on dvrt_pkg, dvrt_front, dvrt_engine
`default_nettype none

// RIP style route table of 64 entries keyed by IPv4 destination. Items enter a
// two deep command queue; the scan engine then reads the table memory one entry
// a cycle, so every accepted item other than an unused opcode passes in turn
// through a dispatch step, 64 entry reads, a registered read stage and an
// update step (a tick has no update step), and one that reports a result also
// waits until that result is popped. An unused opcode is only dispatched.
// Configuration writes take effect at once and are meant for idle periods
// only.
module distance_vector_route_table
  import dvrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] route_dest,
  input  wire logic [31:0] sender_address,
  input  wire logic [4:0]  advertised_cost,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       result_kind,
  output logic             found,
  output logic [31:0]      dest_address,
  output logic [31:0]      next_hop,
  output logic [4:0]       route_cost,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic       [7:0] timeout_seconds;
  logic       [4:0] infinity_cost;
  logic             cmd_valid;
  logic             cmd_take;
  cmd_t             cmd;
  logic             res_valid;
  result_t          res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds <= TIMEOUT_RESET;
      infinity_cost   <= INFINITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_seconds <= cfg_data;
        REG_INFINITY: infinity_cost   <= cfg_data[4:0];
        default:      timeout_seconds <= timeout_seconds;
      endcase
    end
  end

  dvrt_front u_front (
    .clk, .rst, .push, .full, .opcode, .route_dest, .sender_address,
    .advertised_cost, .infinity_cost, .cmd_valid, .cmd, .cmd_take
  );

  dvrt_engine u_engine (
    .clk, .rst, .timeout_seconds, .infinity_cost, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res, .res_take(pop)
  );

  // result transfer
  assign empty        = !res_valid;
  assign result_kind  = res.kind;
  assign found        = res.found;
  assign dest_address = res.dest;
  assign next_hop     = res.hop;
  assign route_cost   = res.cost;

endmodule

`default_nettype wire
